// ===== sv/bcm_pkg.sv =====
// Shared types and codes for the battery charge manager.
package bcm_pkg;

  localparam logic [2:0] ST_UNKNOWN  = 3'd0;
  localparam logic [2:0] ST_DISCH    = 3'd1;
  localparam logic [2:0] ST_WAIT     = 3'd2;
  localparam logic [2:0] ST_CHARGING = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_LINK     = 3'd1;
  localparam logic [2:0] EV_COMPLETE = 3'd2;
  localparam logic [2:0] EV_LOW      = 3'd3;
  localparam logic [2:0] EV_CRIT     = 3'd4;
  localparam logic [2:0] EV_LOSS     = 3'd5;

  localparam logic [2:0] REG_FULL_LEVEL = 3'd0;
  localparam logic [2:0] REG_WARN_LEVEL = 3'd1;
  localparam logic [2:0] REG_CRIT_LEVEL = 3'd2;
  localparam logic [2:0] REG_DUTY_CEIL  = 3'd3;
  localparam logic [2:0] REG_WARN_PER   = 3'd4;
  localparam logic [2:0] REG_DONE_TICKS = 3'd5;

  localparam int SAMPLE_W = 12;

  typedef struct packed {
    logic [11:0] vol_sample;
    logic [11:0] cur_sample;
    logic [11:0] ref_sample;
    logic        charger_connected;
    logic        charge_allowed;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [2:0] battery_state;
    logic [6:0] level_pct;
    logic [9:0] charge_duty;
    logic [3:0] led_brightness;
    logic       led_write;
  } out_word_t;

endpackage

// ===== sv/battery_charge_manager_unit.sv =====
// Top level of the battery charge manager: windows, sequencer and serial divider.
//
//  channel | direction | handshake           | word
//  in_     | input     | in_valid / in_stall  | bcm_pkg::in_word_t
//  out_    | output    | out_valid / out_stall| bcm_pkg::out_word_t
//  cfg_    | input     | cfg_we               | index cfg_addr, data cfg_wdata
//
// Steps: a tick takes an accept step, a summing step per window entry, an averaging
// step, a threshold step, a decision step, the divider when the level lies between
// the low and full marks (one quotient bit per cycle, restoring) and an issue step.
// The first AVG_WINDOW ticks only fill the windows. Reset is synchronous, no clearing pass;
// it clears control state and the windows, not the datapath registers.
// Past warm-up, in_stall stays high from accept until the result word is loaded into the
// output register; a stalled output holds the sequencer in its issue step.
module battery_charge_manager_unit #(
  parameter int AVG_WINDOW = 5,
  parameter int ADC_BITS   = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bcm_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bcm_pkg::out_word_t   out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [9:0]           cfg_wdata
);

  // Sample width after masking to the converter resolution.
  localparam int SW   = (ADC_BITS < bcm_pkg::SAMPLE_W) ? ADC_BITS : bcm_pkg::SAMPLE_W;
  localparam int SUMW = SW + $clog2(AVG_WINDOW);
  localparam int IW   = $clog2(AVG_WINDOW);
  localparam int WUW  = $clog2(AVG_WINDOW + 1);
  localparam int TW   = SW + 2;   // thresholds reach 2.25 times the reference
  localparam int XW   = SW + 5;   // product before the constant divide
  localparam int NUMW = SW + 7;   // (v - low) * 100
  localparam int DW   = TW + 1;
  localparam int CW   = $clog2(NUMW + 1);

  // Window mean by reciprocal multiplication: the reciprocal is rounded up,
  // and the extra IW fraction bits keep the floor exact over the whole sum range.
  localparam int AVG_K = SUMW + IW;
  localparam int AW    = SUMW + AVG_K;
  localparam logic [AW-1:0] AVG_RCP =
    AW'(((64'd1 << AVG_K) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW));

  // Rounded-up reciprocals for the thresholds: /5 at 19 fraction bits, /9 at 21,
  // /3 at 14 (so /48 and /24 are the product shifted by 18 and 17).
  localparam logic [16:0] RCP_5 = 17'd104858;
  localparam logic [17:0] RCP_9 = 18'd233017;
  localparam logic [12:0] RCP_3 = 13'd5462;

  localparam logic [WUW-1:0] WARM_END = WUW'(AVG_WINDOW);
  localparam logic [IW-1:0]  IDX_END  = IW'(AVG_WINDOW - 1);
  localparam logic [CW-1:0]  DIV_END  = CW'(NUMW - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_AVG  = 3'd2;
  localparam logic [2:0] S_THR  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_ISS  = 3'd6;

  function automatic logic [SW-1:0] win_mean(input logic [SUMW-1:0] s);
    logic [AW-1:0] p;
    p = AW'(s) * AVG_RCP;
    return p[AVG_K +: SW];
  endfunction

  // configuration
  logic [6:0] full_lvl_r, warn_lvl_r, crit_lvl_r;
  logic [9:0] duty_ceil_r;
  logic [5:0] warn_per_r;
  logic [7:0] done_ticks_r;

  // windows, oldest at index 0
  logic [SW-1:0] vwin_r [AVG_WINDOW];
  logic [SW-1:0] cwin_r [AVG_WINDOW];
  logic [SW-1:0] rwin_r [AVG_WINDOW];

  logic [2:0]      seq_r, seq_nxt;
  logic [WUW-1:0]  warm_r;
  logic [IW-1:0]   idx_r;
  logic [SUMW-1:0] vsum_r, csum_r, rsum_r;
  logic [SW-1:0]   v_r, c_r, r_r;
  logic            conn_r, allow_r;

  logic [2:0] mode_r, mode_nxt;
  logic [6:0] level_r, level_nxt;
  logic [6:0] warn_cnt_r, warn_cnt_nxt;
  logic [7:0] settle_r, settle_nxt;
  logic [9:0] duty_r, duty_nxt;
  logic [3:0] led_r, led_nxt;
  logic       led_up_r, led_up_nxt;
  logic [2:0] ev_r, ev_nxt;
  logic [3:0] led_out_r, led_out_nxt;
  logic       led_wr_r, led_wr_nxt;

  // divider
  logic [NUMW-1:0] num_r, quo_r;
  logic [TW-1:0]   den_r;
  logic [DW-1:0]   rem_r;
  logic [CW-1:0]   dcnt_r;
  logic [DW-1:0]   trial;
  logic            fits;
  logic [NUMW-1:0] quo_fin;

  bcm_pkg::out_word_t out_r;
  logic               out_valid_r;

  logic acc;
  assign acc      = in_valid && !in_stall;
  assign in_stall = (seq_r != S_IDLE);

  // thresholds from the reference average, held for the decision step
  logic [XW-1:0] r9, r17, r20;
  logic [34:0]   low_p, full_p, high_p;
  logic [29:0]   c3_p;
  assign r9     = XW'(r_r) * XW'(9);
  assign r17    = XW'(r_r) * XW'(17);
  assign r20    = XW'(r_r) * XW'(20);
  assign low_p  = 35'(r9)  * 35'(RCP_5);
  assign full_p = 35'(r20) * 35'(RCP_9);
  assign high_p = 35'(r17) * 35'(RCP_9);
  assign c3_p   = 30'(r_r) * 30'(RCP_3);

  logic [TW-1:0] low_r, full_r, chg_r, high_r;
  logic [SW-1:0] cur50_r, cur100_r, cur600_r;

  logic [TW-1:0] v_ext;
  assign v_ext = TW'(v_r);

  // decision step: state machine, charging step and level preparation
  logic          done_c;
  logic          need_div;
  logic [TW-1:0] den_c;
  always_comb begin
    mode_nxt     = mode_r;
    warn_cnt_nxt = warn_cnt_r;
    settle_nxt   = settle_r;
    duty_nxt     = duty_r;
    led_nxt      = led_r;
    led_up_nxt   = led_up_r;
    ev_nxt       = bcm_pkg::EV_NONE;
    led_out_nxt  = 4'd0;
    led_wr_nxt   = 1'b0;
    done_c       = 1'b0;
    if (conn_r) begin
      unique case (mode_r)
        bcm_pkg::ST_DISCH: begin
          mode_nxt = bcm_pkg::ST_WAIT;
          ev_nxt   = bcm_pkg::EV_LINK;
        end
        bcm_pkg::ST_WAIT: begin
          if (allow_r) mode_nxt = bcm_pkg::ST_CHARGING;
        end
        bcm_pkg::ST_CHARGING: begin
          led_wr_nxt  = 1'b1;
          led_out_nxt = led_r;
          // turn the triangle at its ends, then take one step
          if (led_up_r && led_r >= 4'd10)   led_up_nxt = 1'b0;
          else if (!led_up_r && led_r == 4'd0) led_up_nxt = 1'b1;
          led_nxt = led_up_nxt ? led_r + 4'd1 : led_r - 4'd1;
          if (v_ext <= high_r) begin
            if (c_r <= cur100_r) begin
              if (duty_r < duty_ceil_r) duty_nxt = duty_r + 10'd1;
            end else if (duty_r > 10'd1) duty_nxt = duty_r - 10'd1;
          end else if (v_ext < chg_r) begin
            if (c_r <= cur600_r) begin
              if (duty_r < duty_ceil_r) duty_nxt = duty_r + 10'd1;
            end else if (duty_r > 10'd1) duty_nxt = duty_r - 10'd1;
          end else begin
            if (duty_r > 10'd1) duty_nxt = duty_r - 10'd1;
            if (c_r <= cur50_r) begin
              done_c = (settle_r >= done_ticks_r);
              if (settle_r != 8'hff) settle_nxt = settle_r + 8'd1;
            end
          end
          if (done_c) begin
            settle_nxt = 8'd0;
            duty_nxt   = 10'd0;
            mode_nxt   = bcm_pkg::ST_DONE;
            ev_nxt     = bcm_pkg::EV_COMPLETE;
          end
        end
        bcm_pkg::ST_DONE: begin
          if (!allow_r && level_r < full_lvl_r) begin
            mode_nxt = bcm_pkg::ST_WAIT;
            ev_nxt   = bcm_pkg::EV_LINK;
          end
        end
        default: mode_nxt = bcm_pkg::ST_DISCH;
      endcase
    end else begin
      unique case (mode_r)
        bcm_pkg::ST_DISCH: begin
          if (level_r < warn_lvl_r && !allow_r) begin
            warn_cnt_nxt = warn_cnt_r + 7'd1;
            if (warn_cnt_nxt > 7'(warn_per_r)) begin
              warn_cnt_nxt = 7'd0;
              ev_nxt = (level_r < crit_lvl_r) ? bcm_pkg::EV_CRIT : bcm_pkg::EV_LOW;
            end
          end else begin
            warn_cnt_nxt = 7'd0;
          end
        end
        bcm_pkg::ST_WAIT, bcm_pkg::ST_DONE: begin
          mode_nxt = bcm_pkg::ST_DISCH;
          ev_nxt   = bcm_pkg::EV_LOSS;
        end
        bcm_pkg::ST_CHARGING: begin
          settle_nxt = 8'd0;
          duty_nxt   = 10'd0;
          mode_nxt   = bcm_pkg::ST_DISCH;
          ev_nxt     = bcm_pkg::EV_LOSS;
        end
        default: mode_nxt = bcm_pkg::ST_DISCH;
      endcase
    end

    den_c     = (mode_nxt == bcm_pkg::ST_CHARGING) ? chg_r - low_r : full_r - low_r;
    need_div  = 1'b0;
    level_nxt = level_r;
    if (v_ext > full_r)      level_nxt = 7'd100;
    else if (v_ext > low_r) begin
      if (den_c == '0) level_nxt = 7'd100;
      else             need_div  = 1'b1;
    end else             level_nxt = 7'd0;
  end

  assign trial   = {rem_r[DW-2:0], num_r[NUMW-1]};
  assign fits    = (trial >= DW'(den_r));
  assign quo_fin = {quo_r[NUMW-2:0], fits};

  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      S_IDLE: if (acc && warm_r == WARM_END) seq_nxt = S_SUM;
      S_SUM:  if (idx_r == IDX_END) seq_nxt = S_AVG;
      S_AVG:  seq_nxt = S_THR;
      S_THR:  seq_nxt = S_DEC;
      S_DEC:  seq_nxt = need_div ? S_DIV : S_ISS;
      S_DIV:  if (dcnt_r == DIV_END) seq_nxt = S_ISS;
      S_ISS:  if (!(out_valid_r && out_stall)) seq_nxt = S_IDLE;
      default: seq_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= S_IDLE;
      warm_r       <= '0;
      mode_r       <= bcm_pkg::ST_UNKNOWN;
      level_r      <= 7'd100;
      warn_cnt_r   <= '0;
      settle_r     <= '0;
      duty_r       <= '0;
      led_r        <= '0;
      led_up_r     <= 1'b1;
      out_valid_r  <= 1'b0;
      full_lvl_r   <= 7'd95;
      warn_lvl_r   <= 7'd20;
      crit_lvl_r   <= 7'd10;
      duty_ceil_r  <= 10'd360;
      warn_per_r   <= 6'd30;
      done_ticks_r <= 8'd100;
      for (int i = 0; i < AVG_WINDOW; i++) begin
        vwin_r[i] <= '0;
        cwin_r[i] <= '0;
        rwin_r[i] <= '0;
      end
    end else begin
      seq_r <= seq_nxt;
      // raise valid on issue, drop it once the word is taken
      if (seq_r == S_ISS && !(out_valid_r && out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)                 out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_addr)
          bcm_pkg::REG_FULL_LEVEL: full_lvl_r   <= cfg_wdata[6:0];
          bcm_pkg::REG_WARN_LEVEL: warn_lvl_r   <= cfg_wdata[6:0];
          bcm_pkg::REG_CRIT_LEVEL: crit_lvl_r   <= cfg_wdata[6:0];
          bcm_pkg::REG_DUTY_CEIL:  duty_ceil_r  <= cfg_wdata;
          bcm_pkg::REG_WARN_PER:   warn_per_r   <= cfg_wdata[5:0];
          bcm_pkg::REG_DONE_TICKS: done_ticks_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      unique case (seq_r)
        S_IDLE: begin
          if (acc) begin
            // advance the windows by one sample
            for (int i = 0; i < AVG_WINDOW - 1; i++) begin
              vwin_r[i] <= vwin_r[i+1];
              cwin_r[i] <= cwin_r[i+1];
              rwin_r[i] <= rwin_r[i+1];
            end
            vwin_r[AVG_WINDOW-1] <= in_data.vol_sample[SW-1:0];
            cwin_r[AVG_WINDOW-1] <= in_data.cur_sample[SW-1:0];
            rwin_r[AVG_WINDOW-1] <= in_data.ref_sample[SW-1:0];
            conn_r  <= in_data.charger_connected;
            allow_r <= in_data.charge_allowed;
            if (warm_r != WARM_END) warm_r <= warm_r + WUW'(1);
            idx_r  <= '0;
            vsum_r <= '0;
            csum_r <= '0;
            rsum_r <= '0;
          end
        end
        S_SUM: begin
          vsum_r <= vsum_r + SUMW'(vwin_r[idx_r]);
          csum_r <= csum_r + SUMW'(cwin_r[idx_r]);
          rsum_r <= rsum_r + SUMW'(rwin_r[idx_r]);
          idx_r  <= idx_r + IW'(1);
        end
        S_AVG: begin
          v_r <= win_mean(vsum_r);
          c_r <= win_mean(csum_r);
          r_r <= win_mean(rsum_r);
        end
        S_THR: begin
          low_r    <= low_p[19 +: TW];
          full_r   <= full_p[21 +: TW];
          high_r   <= high_p[21 +: TW];
          chg_r    <= r9[2 +: TW];
          cur50_r  <= c3_p[18 +: SW];
          cur100_r <= c3_p[17 +: SW];
          cur600_r <= r_r >> 2;
        end
        S_DEC: begin
          mode_r     <= mode_nxt;
          warn_cnt_r <= warn_cnt_nxt;
          settle_r   <= settle_nxt;
          duty_r     <= duty_nxt;
          led_r      <= led_nxt;
          led_up_r   <= led_up_nxt;
          ev_r       <= ev_nxt;
          led_out_r  <= led_out_nxt;
          led_wr_r   <= led_wr_nxt;
          level_r    <= level_nxt;
          num_r      <= NUMW'(v_ext - low_r) * NUMW'(100);
          den_r      <= den_c;
          rem_r      <= '0;
          quo_r      <= '0;
          dcnt_r     <= '0;
        end
        S_DIV: begin
          rem_r  <= fits ? trial - DW'(den_r) : trial;
          quo_r  <= quo_fin;
          num_r  <= {num_r[NUMW-2:0], 1'b0};
          dcnt_r <= dcnt_r + CW'(1);
          if (dcnt_r == DIV_END) begin
            level_r <= (quo_fin > NUMW'(100)) ? 7'd100 : quo_fin[6:0];
          end
        end
        S_ISS: begin
          if (!(out_valid_r && out_stall)) begin
            out_r.event_code     <= ev_r;
            out_r.battery_state  <= mode_r;
            out_r.level_pct      <= level_r;
            out_r.charge_duty    <= duty_r;
            out_r.led_brightness <= led_out_r;
            out_r.led_write      <= led_wr_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.level_pct <= 7'd100) else $error("level above 100");
  a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
    led_r <= 4'd10) else $error("led level left triangle");
  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= bcm_pkg::ST_DONE) else $error("undefined mode held");
  a_start_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && warm_r == WARM_END) |=> seq_r == S_SUM) else $error("tick not summed");
`endif

endmodule
